FILE: design/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg: shared types and constants of the looping sample player
// Command codes, register indexes, widths and the sequencer state type.
// ----------------------------------------------------------------------------
package lsp_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int ADDR_W     = 16;
   localparam int POS_W      = 32;
   localparam int COUNT_W    = ADDR_W + 1;
   localparam int DIV_N_W    = 48;
   localparam int DIV_D_W    = 32;
   localparam int DIV_CNT_W  = 6;

   localparam logic [COUNT_W-1:0] SAMPLE_DEPTH = COUNT_W'(1 << ADDR_W);

   typedef enum logic [2:0] {
      CMD_WRITE = 3'd0,
      CMD_PLAY  = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_SEEK  = 3'd3,
      CMD_TICK  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      REG_STEP       = 3'd0,
      REG_COUNT      = 3'd1,
      REG_LOOP_EN    = 3'd2,
      REG_LOOP_START = 3'd3,
      REG_LOOP_END   = 3'd4,
      REG_XFADE      = 3'd5,
      REG_START_OFS  = 3'd6
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_CHECK,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_INT_MUL,
      ST_INT_ADD,
      ST_FADE,
      ST_BL_M1,
      ST_BL_M2,
      ST_BL_SUM,
      ST_BL_DIV,
      ST_ADVANCE,
      ST_OUT
   } state_type;

endpackage

FILE: design/lsp_divider.sv
// ----------------------------------------------------------------------------
// lsp_divider: iterative restoring divider
// One quotient bit per cycle; gives quotient and remainder, done pulses once.
// ----------------------------------------------------------------------------
module lsp_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lsp_pkg::DIV_N_W-1:0] dividend,
   input  logic [lsp_pkg::DIV_D_W-1:0] divisor,
   output logic                        done,
   output logic [lsp_pkg::DIV_N_W-1:0] quotient,
   output logic [lsp_pkg::DIV_D_W-1:0] remainder
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [lsp_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [lsp_pkg::DIV_N_W-1:0]   quo_ff, quo_in;
   logic [lsp_pkg::DIV_D_W-1:0]   rem_ff, rem_in;
   logic [lsp_pkg::DIV_D_W-1:0]   div_ff, div_in;
   logic [lsp_pkg::DIV_D_W:0]     trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[lsp_pkg::DIV_N_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = lsp_pkg::DIV_CNT_W'(lsp_pkg::DIV_N_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = lsp_pkg::DIV_D_W'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[lsp_pkg::DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = trial[lsp_pkg::DIV_D_W-1:0];
            quo_in = {quo_ff[lsp_pkg::DIV_N_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider still busy when done");

endmodule

FILE: design/looping_sample_player.sv
// ----------------------------------------------------------------------------
// looping_sample_player: stereo sample player with loop and crossfade
// Sample memory, interpolated playback, modulo loop wrap and loop crossfade,
// sequenced over one shared multiplier and one iterative divider.
//
//   channel  direction  ports
//   req      in         req_valid, req_stall, req_command .. req_seek_position
//   rsp      out        rsp_valid, rsp_stall, rsp_left_out .. rsp_play_position
//   csr      in         csr_write_en, csr_index, csr_data
//
// Write, play, stop and seek items are taken in the idle state; a tick holds
// req_stall high until its frame enters the output register. A loop wrap
// adds one divider pass, and inside the crossfade a tick adds a second read
// and two divider passes, at one quotient bit a cycle. Reset is synchronous
// and clears control state; the sample memory is not cleared.
// A result waits in the output register while rsp_stall is high.
// ----------------------------------------------------------------------------
module looping_sample_player (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_command,
   input  logic [15:0]                 req_sample_address,
   input  logic signed [15:0]          req_left_sample,
   input  logic signed [15:0]          req_right_sample,
   input  logic [31:0]                 req_seek_position,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [15:0]          rsp_left_out,
   output logic signed [15:0]          rsp_right_out,
   output logic                        rsp_is_playing,
   output logic [31:0]                 rsp_play_position,
   input  logic                        csr_write_en,
   input  logic [2:0]                  csr_index,
   input  logic [31:0]                 csr_data
);

   localparam int PW = lsp_pkg::POS_W;
   localparam int CW = lsp_pkg::COUNT_W;
   localparam int AW = lsp_pkg::ADDR_W;
   localparam int FB = lsp_pkg::FRAC_BITS;

   // configuration
   logic [PW-1:0] step_ff, loop_start_ff, loop_end_ff, xfade_ff, start_ofs_ff;
   logic [CW-1:0] count_reg_ff;
   logic          loop_en_ff;

   // playback state and work registers
   lsp_pkg::state_type state_ff, state_in;
   logic [PW-1:0]        position_ff, position_in;
   logic                 playing_ff, playing_in;
   logic [PW-1:0]        p_ff, p_in;
   logic [PW-1:0]        rdpos_ff, rdpos_in;
   logic [PW-1:0]        fade_ff, fade_in;
   logic [PW-1:0]        dist_ff, dist_in;
   logic                 pass_ff, pass_in;
   logic                 chan_ff, chan_in;
   logic [31:0]          samp0_ff, samp0_in, samp1_ff, samp1_in;
   logic signed [15:0]   lo_ff, lo_in, ro_ff, ro_in, fl_ff, fl_in, fr_ff, fr_in;
   logic signed [51:0]   prod_ff, prod_in, acc_ff, acc_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]   rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;
   logic                 rsp_play_ff, rsp_play_in;
   logic [PW-1:0]        rsp_pos_ff, rsp_pos_in;

   // sample memory
   logic [31:0]          mem [1 << AW];
   logic [31:0]          rd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic                 mem_we;

   // shared multiplier
   logic signed [17:0]   mul_a;
   logic signed [33:0]   mul_b;
   logic signed [51:0]   mul_prod;

   // divider
   logic                 div_start, div_done;
   logic [lsp_pkg::DIV_N_W-1:0] div_dividend, div_quo;
   logic [lsp_pkg::DIV_D_W-1:0] div_divisor, div_rem;

   // derived values
   logic                 req_fire, looping;
   logic [CW-1:0]        count;
   logic [PW:0]          dur, lim, fade_pos, adv;
   logic [PW-1:0]        span, fade_w, fade_from;
   logic [AW-1:0]        idx;
   logic [CW-1:0]        nxt;
   logic signed [16:0]   diff, bdiff;
   logic signed [15:0]   base, fbase, ival;
   logic signed [51:0]   rnd;
   logic [51:0]          bsum;

   assign req_fire = req_valid && !req_stall;
   assign req_stall = (state_ff != lsp_pkg::ST_IDLE);
   assign looping  = loop_en_ff && (loop_end_ff > loop_start_ff);
   assign count    = (count_reg_ff > lsp_pkg::SAMPLE_DEPTH) ? lsp_pkg::SAMPLE_DEPTH
                                                             : count_reg_ff;
   assign dur      = {count, {FB{1'b0}}};
   assign lim      = {count - 1'b1, {FB{1'b0}}};
   assign span     = loop_end_ff - loop_start_ff;
   assign fade_w   = looping ? ((xfade_ff < {1'b0, span[PW-1:1]}) ? xfade_ff
                                                                 : {1'b0, span[PW-1:1]})
                             : '0;
   assign fade_from = loop_end_ff - fade_w;
   assign fade_pos = {1'b0, loop_start_ff} + {1'b0, p_ff - fade_from};
   assign adv      = {1'b0, p_ff} + {1'b0, step_ff};
   assign idx      = rdpos_ff[PW-1:FB];
   assign nxt      = ({1'b0, idx} + 1'b1 < count) ? {1'b0, idx} + 1'b1 : count - 1'b1;
   assign diff     = chan_ff ? ($signed({samp1_ff[15], samp1_ff[15:0]})
                               - $signed({samp0_ff[15], samp0_ff[15:0]}))
                             : ($signed({samp1_ff[31], samp1_ff[31:16]})
                               - $signed({samp0_ff[31], samp0_ff[31:16]}));
   assign base     = chan_ff ? $signed(samp0_ff[15:0]) : $signed(samp0_ff[31:16]);
   assign rnd      = (prod_ff + 52'sd32768) >>> FB;
   assign ival     = base + $signed(rnd[15:0]);
   assign fbase    = chan_ff ? ro_ff : lo_ff;
   assign bdiff    = chan_ff ? ({fr_ff[15], fr_ff} - {ro_ff[15], ro_ff})
                             : ({fl_ff[15], fl_ff} - {lo_ff[15], lo_ff});
   assign bsum     = 52'(acc_ff + prod_ff) + {20'b0, 1'b0, fade_ff[PW-1:1]};
   assign mul_prod = mul_a * mul_b;

   always_comb begin
      state_in     = state_ff;
      position_in  = position_ff;
      playing_in   = playing_ff;
      p_in         = p_ff;
      rdpos_in     = rdpos_ff;
      fade_in      = fade_ff;
      dist_in      = dist_ff;
      pass_in      = pass_ff;
      chan_in      = chan_ff;
      samp0_in     = samp0_ff;
      samp1_in     = samp1_ff;
      lo_in        = lo_ff;
      ro_in        = ro_ff;
      fl_in        = fl_ff;
      fr_in        = fr_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_play_in  = rsp_play_ff;
      rsp_pos_in   = rsp_pos_ff;
      rd_addr      = idx;
      mem_we       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_dividend = {16'b0, p_ff - loop_end_ff};
      div_divisor  = span;

      case (state_ff)
         lsp_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_command)
                  lsp_pkg::CMD_WRITE: mem_we = 1'b1;
                  lsp_pkg::CMD_PLAY:  playing_in = 1'b1;
                  lsp_pkg::CMD_STOP: begin
                     playing_in  = 1'b0;
                     position_in = start_ofs_ff;
                  end
                  lsp_pkg::CMD_SEEK:  position_in = req_seek_position;
                  lsp_pkg::CMD_TICK: begin
                     p_in = position_ff;
                     if (!playing_ff) begin
                        lo_in    = '0;
                        ro_in    = '0;
                        state_in = lsp_pkg::ST_OUT;
                     end else if (looping && position_ff >= loop_end_ff) begin
                        div_start    = 1'b1;
                        div_dividend = {16'b0, position_ff - loop_end_ff};
                        state_in     = lsp_pkg::ST_MOD;
                     end else begin
                        state_in = lsp_pkg::ST_CHECK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         lsp_pkg::ST_MOD: begin
            if (div_done) begin
               p_in     = loop_start_ff + div_rem;
               state_in = lsp_pkg::ST_CHECK;
            end
         end
         lsp_pkg::ST_CHECK: begin
            if ({1'b0, p_ff} >= dur) begin
               playing_in  = 1'b0;
               position_in = p_ff;
               lo_in       = '0;
               ro_in       = '0;
               state_in    = lsp_pkg::ST_OUT;
            end else begin
               rdpos_in = p_ff;
               pass_in  = 1'b0;
               state_in = lsp_pkg::ST_RD0;
            end
         end
         lsp_pkg::ST_RD0: state_in = lsp_pkg::ST_RD1;
         lsp_pkg::ST_RD1: begin
            rd_addr  = nxt[AW-1:0];
            samp0_in = rd_data_ff;
            state_in = lsp_pkg::ST_RD2;
         end
         lsp_pkg::ST_RD2: begin
            samp1_in = rd_data_ff;
            chan_in  = 1'b0;
            state_in = lsp_pkg::ST_INT_MUL;
         end
         lsp_pkg::ST_INT_MUL: begin
            mul_a    = 18'(diff);
            mul_b    = {18'b0, rdpos_ff[FB-1:0]};
            prod_in  = mul_prod;
            state_in = lsp_pkg::ST_INT_ADD;
         end
         lsp_pkg::ST_INT_ADD: begin
            case ({pass_ff, chan_ff})
               2'b00:   lo_in = ival;
               2'b01:   ro_in = ival;
               2'b10:   fl_in = ival;
               default: fr_in = ival;
            endcase
            if (!chan_ff) begin
               chan_in  = 1'b1;
               state_in = lsp_pkg::ST_INT_MUL;
            end else if (!pass_ff) begin
               state_in = lsp_pkg::ST_FADE;
            end else begin
               chan_in  = 1'b0;
               state_in = lsp_pkg::ST_BL_M1;
            end
         end
         lsp_pkg::ST_FADE: begin
            if (fade_w != '0 && p_ff > fade_from) begin
               fade_in  = fade_w;
               dist_in  = p_ff - fade_from;
               rdpos_in = (fade_pos > lim) ? lim[PW-1:0] : fade_pos[PW-1:0];
               pass_in  = 1'b1;
               state_in = lsp_pkg::ST_RD0;
            end else begin
               state_in = lsp_pkg::ST_ADVANCE;
            end
         end
         lsp_pkg::ST_BL_M1: begin
            // offset to unsigned so the weighted sum stays non-negative
            mul_a    = {2'b00, ~fbase[15], fbase[14:0]};
            mul_b    = {2'b00, fade_ff};
            prod_in  = mul_prod;
            state_in = lsp_pkg::ST_BL_M2;
         end
         lsp_pkg::ST_BL_M2: begin
            acc_in   = prod_ff;
            mul_a    = 18'(bdiff);
            mul_b    = {2'b00, dist_ff};
            prod_in  = mul_prod;
            state_in = lsp_pkg::ST_BL_SUM;
         end
         lsp_pkg::ST_BL_SUM: begin
            div_start    = 1'b1;
            div_dividend = bsum[lsp_pkg::DIV_N_W-1:0];
            div_divisor  = fade_ff;
            state_in     = lsp_pkg::ST_BL_DIV;
         end
         lsp_pkg::ST_BL_DIV: begin
            if (div_done) begin
               // drop the offset again
               if (!chan_ff) begin
                  lo_in    = $signed({~div_quo[15], div_quo[14:0]});
                  chan_in  = 1'b1;
                  state_in = lsp_pkg::ST_BL_M1;
               end else begin
                  ro_in    = $signed({~div_quo[15], div_quo[14:0]});
                  state_in = lsp_pkg::ST_ADVANCE;
               end
            end
         end
         lsp_pkg::ST_ADVANCE: begin
            position_in = adv[PW] ? {PW{1'b1}} : adv[PW-1:0];
            state_in    = lsp_pkg::ST_OUT;
         end
         lsp_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = lo_ff;
               rsp_right_in = ro_ff;
               rsp_play_in  = playing_ff;
               rsp_pos_in   = position_ff;
               state_in     = lsp_pkg::ST_IDLE;
            end
         end
         default: state_in = lsp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[req_sample_address] <= {req_left_sample, req_right_sample};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= 32'h0001_0000;
         count_reg_ff  <= '0;
         loop_en_ff    <= 1'b0;
         loop_start_ff <= '0;
         loop_end_ff   <= '0;
         xfade_ff      <= '0;
         start_ofs_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            lsp_pkg::REG_STEP:       step_ff       <= csr_data;
            lsp_pkg::REG_COUNT:      count_reg_ff  <= csr_data[CW-1:0];
            lsp_pkg::REG_LOOP_EN:    loop_en_ff    <= csr_data[0];
            lsp_pkg::REG_LOOP_START: loop_start_ff <= csr_data;
            lsp_pkg::REG_LOOP_END:   loop_end_ff   <= csr_data;
            lsp_pkg::REG_XFADE:      xfade_ff      <= csr_data;
            lsp_pkg::REG_START_OFS:  start_ofs_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsp_pkg::ST_IDLE;
         position_ff  <= '0;
         playing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         position_ff  <= position_in;
         playing_ff   <= playing_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff         <= p_in;
      rdpos_ff     <= rdpos_in;
      fade_ff      <= fade_in;
      dist_ff      <= dist_in;
      pass_ff      <= pass_in;
      chan_ff      <= chan_in;
      samp0_ff     <= samp0_in;
      samp1_ff     <= samp1_in;
      lo_ff        <= lo_in;
      ro_ff        <= ro_in;
      fl_ff        <= fl_in;
      fr_ff        <= fr_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_play_ff  <= rsp_play_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   lsp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_out      = rsp_left_ff;
   assign rsp_right_out     = rsp_right_ff;
   assign rsp_is_playing    = rsp_play_ff;
   assign rsp_play_position = rsp_pos_ff;

   a_div_start_waits: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (state_ff == lsp_pkg::ST_MOD || state_ff == lsp_pkg::ST_BL_DIV))
      else $error("divider started outside a wait state");
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == lsp_pkg::ST_OUT)
      else $error("result raised outside output state");
   a_pos_writers: assert property (@(posedge clock) disable iff (reset)
      !$stable(position_ff) |-> ($past(state_ff) == lsp_pkg::ST_IDLE
                                 || $past(state_ff) == lsp_pkg::ST_CHECK
                                 || $past(state_ff) == lsp_pkg::ST_ADVANCE))
      else $error("position changed in a wrong state");

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the looping sample player
// Loads sample memory, plays through directed and random command streams
// under several loop and crossfade settings, and checks every tick frame
// against an in-bench model of the interpolation, wrap and crossfade.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int LIMIT_CYCLES = 3000000;
   localparam int NUM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int FB = lsp_pkg::FRAC_BITS;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               playing;
      logic [31:0]        pos;
   } frame_type;

   typedef struct {
      lsp_pkg::cmd_type cmd;
      logic [15:0] addr;
      logic [15:0] lval;
      logic [15:0] rval;
      logic [31:0] seek;
      logic        known;
      frame_type   frame;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_command = 3'd0;
   logic [15:0] req_sample_address = 16'd0;
   logic signed [15:0] req_left_sample = 16'sd0;
   logic signed [15:0] req_right_sample = 16'sd0;
   logic [31:0] req_seek_position = 32'd0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_left_out;
   logic signed [15:0] rsp_right_out;
   logic rsp_is_playing;
   logic [31:0] rsp_play_position;
   logic csr_write_en = 1'b0;
   logic [2:0] csr_index = 3'd0;
   logic [31:0] csr_data = 32'd0;

   looping_sample_player dut (.*);

   // model state
   logic [31:0] mem_model [0:65535];
   logic [31:0] m_pos;
   logic        m_playing;
   logic [31:0] m_step, m_lstart, m_lend, m_xfade, m_ofs;
   logic [16:0] m_count;
   logic        m_loop_en;

   frame_type expected_frames [$];
   int     error_count = 0;
   int     cycle_count = 0;
   bit     quiet_tail = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // round(a + (b - a) * num / den), halves up
   function automatic int mix_round(int a, int b, longint unsigned num,
                                    longint unsigned den);
      longint acc;
      longint unsigned q;
      acc = longint'(a) * longint'(den) + longint'(b - a) * longint'(num)
            + 64'sd32768 * longint'(den);
      q = (longint'(acc) + den / 2) / den;
      return int'(q) - 32768;
   endfunction

   task automatic interp_at(input longint unsigned p, input longint unsigned cnt,
                            output int l, output int r);
      longint unsigned idx, nxt, fr;
      logic [31:0] s0, s1;
      idx = p >> FB;
      fr = p & 64'hFFFF;
      nxt = (idx + 1 < cnt) ? idx + 1 : cnt - 1;
      s0 = mem_model[idx[15:0]];
      s1 = mem_model[nxt[15:0]];
      l = mix_round(int'($signed(s0[31:16])), int'($signed(s1[31:16])), fr, 65536);
      r = mix_round(int'($signed(s0[15:0])), int'($signed(s1[15:0])), fr, 65536);
   endtask

   // advance the player model by one item, returning a frame for ticks
   task automatic predict_player(input stim_row_type it, output bit has_frame,
                                 output frame_type f);
      longint unsigned cnt, dur, a, b, p, fade, d, fp, lim;
      int lo, ro, fl, fr;
      bit looping;
      has_frame = 0;
      lo = 0;
      ro = 0;
      case (it.cmd)
         lsp_pkg::CMD_WRITE: mem_model[it.addr] = {it.lval, it.rval};
         lsp_pkg::CMD_PLAY: m_playing = 1;
         lsp_pkg::CMD_STOP: begin
            m_playing = 0;
            m_pos = m_ofs;
         end
         lsp_pkg::CMD_SEEK: m_pos = it.seek;
         lsp_pkg::CMD_TICK: begin
            has_frame = 1;
            if (m_playing) begin
               cnt = (m_count > 17'd65536) ? 65536 : m_count;
               dur = cnt << FB;
               a = m_lstart;
               b = m_lend;
               p = m_pos;
               looping = m_loop_en && b > a;
               if (looping && p >= b) p = a + (p - b) % (b - a);
               if (p >= dur) begin
                  m_playing = 0;
                  m_pos = p[31:0];
               end else begin
                  fade = looping ? (b - a) >> 1 : 0;
                  interp_at(p, cnt, lo, ro);
                  if (m_xfade < fade) fade = m_xfade;
                  if (looping && fade > 0 && p > b - fade) begin
                     d = p - (b - fade);
                     fp = a + d;
                     lim = (cnt - 1) << FB;
                     if (fp > lim) fp = lim;
                     interp_at(fp, cnt, fl, fr);
                     lo = mix_round(lo, fl, d, fade);
                     ro = mix_round(ro, fr, d, fade);
                  end
                  p += m_step;
                  m_pos = (p > 64'hFFFFFFFF) ? 32'hFFFFFFFF : p[31:0];
               end
            end
            f.left = lo[15:0];
            f.right = ro[15:0];
            f.playing = m_playing;
            f.pos = m_pos;
         end
         default: ;
      endcase
   endtask

   // result checker with random stall
   initial begin
      int burst;
      frame_type want;
      burst = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               report_mismatch("unexpected frame", rsp_play_position, 0);
            end else begin
               want = expected_frames.pop_front();
               if (rsp_left_out !== want.left)
                  report_mismatch("left_out", 32'(rsp_left_out), 32'(want.left));
               if (rsp_right_out !== want.right)
                  report_mismatch("right_out", 32'(rsp_right_out), 32'(want.right));
               if (rsp_is_playing !== want.playing)
                  report_mismatch("is_playing", 32'(rsp_is_playing), 32'(want.playing));
               if (rsp_play_position !== want.pos)
                  report_mismatch("play_position", rsp_play_position, want.pos);
            end
         end
         if (burst > 0) begin
            burst--;
            rsp_stall <= (burst > 0);
         end else if (!quiet_tail && !reset && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_reg(input lsp_pkg::reg_index_type idx, input logic [31:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         lsp_pkg::REG_STEP:       m_step = val;
         lsp_pkg::REG_COUNT:      m_count = val[16:0];
         lsp_pkg::REG_LOOP_EN:    m_loop_en = val[0];
         lsp_pkg::REG_LOOP_START: m_lstart = val;
         lsp_pkg::REG_LOOP_END:   m_lend = val;
         lsp_pkg::REG_XFADE:      m_xfade = val;
         lsp_pkg::REG_START_OFS:  m_ofs = val;
         default: ;
      endcase
   endtask

   // send one item; leaves valid high, caller drops it when done
   task automatic send_item(input stim_row_type it);
      bit has_frame;
      frame_type f;
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= it.cmd;
      req_sample_address <= it.addr;
      req_left_sample <= it.lval;
      req_right_sample <= it.rval;
      req_seek_position <= it.seek;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_player(it, has_frame, f);
      if (has_frame) begin
         if (it.known && f !== it.frame)
            report_mismatch("directed table", f.pos, it.frame.pos);
         expected_frames.push_back(f);
      end
   endtask

   task automatic drain_block;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_frames.size() != 0) @(posedge clock);
      // a write-only tail may still be in flight
      repeat (250) @(posedge clock);
   endtask

   function automatic stim_row_type mk(lsp_pkg::cmd_type c, logic [15:0] ad,
                                       logic [15:0] l, logic [15:0] r, logic [31:0] s);
      stim_row_type it;
      it.cmd = c;
      it.addr = ad;
      it.lval = l;
      it.rval = r;
      it.seek = s;
      it.known = 0;
      it.frame = '0;
      return it;
   endfunction

   function automatic logic [31:0] pick_pos(int cnt);
      case ($urandom_range(0, 5))
         0: return 32'($urandom_range(0, cnt)) << FB;
         1: return $urandom();
         2: return (32'(cnt) << FB) - 32'($urandom_range(0, 3));
         default: return $urandom_range(0, (cnt << FB) + 65535);
      endcase
   endfunction

   initial begin
      stim_row_type table_rows [$];
      stim_row_type it;
      int cnt, i, ph, n;
      m_pos = 0;
      m_playing = 0;
      m_step = 32'd65536;
      m_count = 0;
      m_loop_en = 0;
      m_lstart = 0;
      m_lend = 0;
      m_xfade = 0;
      m_ofs = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: stopped tick after reset, extremes, unused command
      it = mk(lsp_pkg::CMD_TICK, 0, 0, 0, 0);
      it.known = 1;
      table_rows.push_back(it);
      table_rows.push_back(mk(lsp_pkg::cmd_type'(3'd7), 16'hFFFF, 16'h8000, 16'h7FFF, 0));
      table_rows.push_back(mk(lsp_pkg::cmd_type'(3'd5), 0, 0, 0, 0));
      table_rows.push_back(mk(lsp_pkg::CMD_WRITE, 0, 16'h7FFF, 16'h8000, 0));
      table_rows.push_back(mk(lsp_pkg::CMD_WRITE, 1, 16'h8000, 16'h7FFF, 0));
      table_rows.push_back(mk(lsp_pkg::CMD_WRITE, 2, 16'h0001, 16'hFFFF, 0));
      table_rows.push_back(mk(lsp_pkg::CMD_WRITE, 3, 16'h0000, 16'h0000, 0));
      table_rows.push_back(mk(lsp_pkg::CMD_WRITE, 16'hFFFF, 16'h1234, 16'hEDCB, 0));
      table_rows.push_back(mk(lsp_pkg::CMD_PLAY, 0, 0, 0, 0));
      // playing with count zero: end of data at position zero
      it = mk(lsp_pkg::CMD_TICK, 0, 0, 0, 0);
      it.known = 1;
      it.frame.playing = 0;
      table_rows.push_back(it);
      foreach (table_rows[k]) send_item(table_rows[k]);
      drain_block();

      write_reg(lsp_pkg::REG_COUNT, 32'd4);
      write_reg(lsp_pkg::REG_START_OFS, 32'h8000);
      table_rows.delete();
      table_rows.push_back(mk(lsp_pkg::CMD_PLAY, 0, 0, 0, 0));
      it = mk(lsp_pkg::CMD_TICK, 0, 0, 0, 0);
      it.known = 1;
      it.frame = '{16'sh7FFF, -16'sh8000, 1'b1, 32'h10000};
      table_rows.push_back(it);
      table_rows.push_back(mk(lsp_pkg::CMD_SEEK, 0, 0, 0, 32'h8000));
      table_rows.push_back(mk(lsp_pkg::CMD_TICK, 0, 0, 0, 0));
      table_rows.push_back(mk(lsp_pkg::CMD_SEEK, 0, 0, 0, 32'h38000));
      table_rows.push_back(mk(lsp_pkg::CMD_TICK, 0, 0, 0, 0));
      table_rows.push_back(mk(lsp_pkg::CMD_TICK, 0, 0, 0, 0));
      table_rows.push_back(mk(lsp_pkg::CMD_STOP, 0, 0, 0, 0));
      it = mk(lsp_pkg::CMD_TICK, 0, 0, 0, 0);
      it.known = 1;
      it.frame = '{16'sh0, 16'sh0, 1'b0, 32'h8000};
      table_rows.push_back(it);
      table_rows.push_back(mk(lsp_pkg::CMD_SEEK, 0, 0, 0, 32'hFFFFFFFF));
      table_rows.push_back(mk(lsp_pkg::CMD_PLAY, 0, 0, 0, 0));
      table_rows.push_back(mk(lsp_pkg::CMD_TICK, 0, 0, 0, 0));
      foreach (table_rows[k]) send_item(table_rows[k]);
      drain_block();

      // phases: loop and crossfade settings, extremes first and last
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: cnt = 4;
            1: cnt = 2;
            2: cnt = 64;
            3: cnt = 1;
            4: cnt = 65536;
            default: cnt = 32;
         endcase
         write_reg(lsp_pkg::REG_COUNT, (ph == 5) ? 32'h1FFFF : 32'(cnt));
         write_reg(lsp_pkg::REG_STEP, (ph == 1) ? 32'hFFFFFFFF : (ph == 3) ? 32'd0
                   : $urandom_range(1, 3 << FB));
         write_reg(lsp_pkg::REG_LOOP_EN, (ph == 0) ? 32'd0 : 32'd1);
         // big counts: the loop lies within the first 256 entries; reads reach entry 256 at most
         write_reg(lsp_pkg::REG_LOOP_START, (ph == 4) ? 32'd0
                   : (ph == 5) ? 32'($urandom_range(0, 100 << FB)) : pick_pos(cnt) >> 1);
         write_reg(lsp_pkg::REG_LOOP_END, (ph >= 4)
                   ? 32'($urandom_range(101 << FB, 256 << FB)) : pick_pos(cnt));
         write_reg(lsp_pkg::REG_XFADE, (ph == 2) ? 32'hFFFFFFFF
                   : $urandom_range(0, 40 << FB));
         write_reg(lsp_pkg::REG_START_OFS, pick_pos(cnt));
         if (ph == 5) cnt = 65536;
         // fill every entry that a read can reach
         n = (cnt > 256) ? 257 : cnt;
         for (i = 0; i < n; i++)
            send_item(mk(lsp_pkg::CMD_WRITE, 16'(i), 16'($urandom), 16'($urandom), 0));
         send_item(mk(lsp_pkg::CMD_PLAY, 0, 0, 0, 0));
         quiet_tail = (ph == NUM_PHASES - 1);
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            case ($urandom_range(0, 19))
               0: send_item(mk(lsp_pkg::CMD_WRITE, 16'($urandom_range(0, cnt - 1)),
                               16'($urandom), 16'($urandom), 0));
               1, 2: send_item(mk(lsp_pkg::CMD_PLAY, 0, 0, 0, 0));
               3: send_item(mk(lsp_pkg::CMD_STOP, 0, 0, 0, 0));
               4, 5: send_item(mk(lsp_pkg::CMD_SEEK, 0, 0, 0,
                                  (cnt > 256) ? pick_pos(256) : pick_pos(cnt)));
               6: send_item(mk(lsp_pkg::cmd_type'(3'($urandom_range(5, 7))),
                               16'($urandom), 16'($urandom), 16'($urandom), $urandom()));
               default: send_item(mk(lsp_pkg::CMD_TICK, 0, 0, 0, 0));
            endcase
         end
         drain_block();
      end

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/lsp_pkg.sv
design/lsp_divider.sv
design/looping_sample_player.sv
verif/tb_top.sv
